// ----- rtl/core/tapid_pkg.sv -----
package tapid_pkg;

    // Q8.24 thresholds, rounded to nearest
    localparam logic signed [31:0] SETTLE_ATT  = 32'sd167772;
    localparam logic signed [31:0] SETTLE_RATE = 32'sd671089;
    localparam logic signed [31:0] CLAMP_ATT   = 32'sd2852127;
    localparam logic signed [31:0] CLAMP_INT   = 32'sd167772;
    localparam logic signed [31:0] CLAMP_RATE  = 32'sd167772160;
    localparam logic [30:0]        LIMIT_RESET = 31'd16777;

    localparam logic [2:0] CFG_GAIN_P = 3'd0;
    localparam logic [2:0] CFG_GAIN_I = 3'd1;
    localparam logic [2:0] CFG_GAIN_D = 3'd2;
    localparam logic [2:0] CFG_ROW_A  = 3'd3;
    localparam logic [2:0] CFG_ROW_B  = 3'd4;
    localparam logic [2:0] CFG_ROW_C  = 3'd5;
    localparam logic [2:0] CFG_LIMIT  = 3'd6;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_PREP, OP_MUL, OP_MAX,
        OP_DIV_INIT, OP_DIV_STEP, OP_DIV_END, OP_OUT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       align;
        logic [1:0] grp;
        logic [1:0] term;
        logic [1:0] lane;
        logic [4:0] bitn;
    } t_cmd;

    typedef struct packed {
        logic scaled;
    } t_stat;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_PID, S_PWAIT, S_ALN, S_AWAIT, S_MAX,
        S_DINIT, S_DSTEP, S_DEND, S_OUT
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
        if (v > 56'sd2147483647)
            sat32 = 32'sh7FFFFFFF;
        else if (v < -56'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

endpackage

// ----- rtl/core/tapid_ctrl.sv -----
module tapid_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_stall,
    input  tapid_pkg::t_stat i_stat,
    output tapid_pkg::t_cmd  o_cmd,
    output logic            o_in_stall,
    output logic            o_out_valid
);
    import tapid_pkg::*;

    t_state r_state, n_state;
    logic [1:0] r_grp, n_grp, r_term, n_term, r_lane, n_lane;
    logic [4:0] r_bit, n_bit;
    logic       r_wait, n_wait;
    logic       r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_grp    <= '0;
            r_term   <= '0;
            r_lane   <= '0;
            r_bit    <= '0;
            r_wait   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_grp    <= n_grp;
            r_term   <= n_term;
            r_lane   <= n_lane;
            r_bit    <= n_bit;
            r_wait   <= n_wait;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_grp    = r_grp;
        n_term   = r_term;
        n_lane   = r_lane;
        n_bit    = r_bit;
        n_wait   = r_wait;
        n_ovalid = r_ovalid && i_out_stall;
        o_cmd    = '{op: OP_NONE, default: '0};
        o_cmd.grp   = r_grp;
        o_cmd.term  = r_term;
        o_cmd.lane  = r_lane;
        o_cmd.bitn  = r_bit;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.op = OP_PREP;
                n_grp    = '0;
                n_term   = '0;
                n_state  = S_PID;
            end
            S_PID, S_ALN: begin
                o_cmd.op    = OP_MUL;
                o_cmd.align = (r_state == S_ALN);
                if (r_term == 2'd2) begin
                    n_term = '0;
                    if (r_grp == 2'd2) begin
                        n_grp   = '0;
                        n_wait  = 1'b0;
                        n_state = (r_state == S_PID) ? S_PWAIT : S_AWAIT;
                    end else begin
                        n_grp = r_grp + 2'd1;
                    end
                end else begin
                    n_term = r_term + 2'd1;
                end
            end
            S_PWAIT, S_AWAIT: begin
                // let the last product drain through the accumulator
                n_wait = 1'b1;
                if (r_wait)
                    n_state = (r_state == S_PWAIT) ? S_ALN : S_MAX;
            end
            S_MAX: begin
                o_cmd.op = OP_MAX;
                n_lane   = '0;
                n_state  = S_DINIT;
            end
            S_DINIT: begin
                if (i_stat.scaled) begin
                    o_cmd.op = OP_DIV_INIT;
                    n_bit    = 5'd30;
                    n_state  = S_DSTEP;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DSTEP: begin
                o_cmd.op = OP_DIV_STEP;
                if (r_bit == 5'd0)
                    n_state = S_DEND;
                else
                    n_bit = r_bit - 5'd1;
            end
            S_DEND: begin
                o_cmd.op = OP_DIV_END;
                if (r_lane == 2'd2) begin
                    n_state = S_OUT;
                end else begin
                    n_lane  = r_lane + 2'd1;
                    n_state = S_DINIT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    o_cmd.op = OP_OUT;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;

endmodule

// ----- rtl/core/tapid_dp.sv -----
module tapid_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tapid_pkg::t_cmd     i_cmd,
    output tapid_pkg::t_stat    o_stat,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [59:0]         i_cfg_data,
    input  logic signed [31:0]  i_att_err_x,
    input  logic signed [31:0]  i_att_err_y,
    input  logic signed [31:0]  i_att_err_z,
    input  logic signed [31:0]  i_rate_err_x,
    input  logic signed [31:0]  i_rate_err_y,
    input  logic signed [31:0]  i_rate_err_z,
    input  logic                i_restart,
    output logic                o_settled,
    output logic signed [31:0]  o_body_torque_x,
    output logic signed [31:0]  o_body_torque_y,
    output logic signed [31:0]  o_body_torque_z,
    output logic signed [31:0]  o_wheel_torque_a,
    output logic signed [31:0]  o_wheel_torque_b,
    output logic signed [31:0]  o_wheel_torque_c,
    output logic signed [18:0]  o_int_lim_x,
    output logic signed [18:0]  o_int_lim_y,
    output logic signed [18:0]  o_int_lim_z,
    output logic                o_wheel_scaled
);
    import tapid_pkg::*;

    logic [59:0] r_gp, r_gi, r_gd, r_row_a, r_row_b, r_row_c;
    logic [30:0] r_lim;

    logic signed [31:0] r_att [3];
    logic signed [31:0] r_rate [3];
    logic               r_rst;
    logic signed [31:0] r_pa [3];
    logic signed [31:0] r_pi [3];
    logic signed [31:0] r_acl [3];
    logic signed [31:0] r_rcl [3];
    logic signed [31:0] r_int [3];
    logic               r_settled;
    logic signed [31:0] r_body [3];
    logic signed [37:0] r_wheel [3];

    logic signed [51:0] r_prod;
    logic               r_pv, r_palign;
    logic [1:0]         r_pgrp, r_pterm;
    logic signed [55:0] r_acc;

    logic [37:0] r_wmax, r_wmag;
    logic        r_wneg, r_scaled;
    logic [37:0] r_rem;
    logic [31:0] r_q;

    function automatic logic signed [19:0] f20(input logic [59:0] r, input logic [1:0] i);
        case (i)
            2'd0:    f20 = r[19:0];
            2'd1:    f20 = r[39:20];
            default: f20 = r[59:40];
        endcase
    endfunction

    function automatic logic signed [31:0] clampv(input logic signed [33:0] v,
                                                  input logic signed [31:0] lim);
        if (v > 34'(lim))
            clampv = lim;
        else if (v < -34'(lim))
            clampv = -lim;
        else
            clampv = v[31:0];
    endfunction

    function automatic logic [37:0] mag38(input logic signed [37:0] v);
        mag38 = v[37] ? 38'(-v) : 38'(v);
    endfunction

    // settle test, trapezoid integral and clamps
    logic               c_settled;
    logic signed [31:0] c_int [3];
    always_comb begin
        logic signed [32:0] s;
        logic signed [33:0] t;
        logic signed [31:0] pa, pi;
        c_settled = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (r_att[i] > SETTLE_ATT || r_att[i] < -SETTLE_ATT)
                c_settled = 1'b0;
            if (r_rate[i] > SETTLE_RATE || r_rate[i] < -SETTLE_RATE)
                c_settled = 1'b0;
        end
        for (int i = 0; i < 3; i++) begin
            pa = r_rst ? 32'sd0 : r_pa[i];
            pi = r_rst ? 32'sd0 : r_pi[i];
            s  = 33'(r_att[i]) + 33'(pa);
            t  = 34'(pi) + 34'(s >>> 1);
            c_int[i] = c_settled ? clampv(t, CLAMP_INT) : 32'sd0;
        end
    end

    // shared multiplier operands
    logic signed [31:0] c_ma;
    logic signed [19:0] c_mb;
    logic signed [51:0] c_mul;
    always_comb begin
        if (i_cmd.align) begin
            case (i_cmd.term)
                2'd0:    c_ma = r_body[0];
                2'd1:    c_ma = r_body[1];
                default: c_ma = r_body[2];
            endcase
            case (i_cmd.grp)
                2'd0:    c_mb = f20(r_row_a, i_cmd.term);
                2'd1:    c_mb = f20(r_row_b, i_cmd.term);
                default: c_mb = f20(r_row_c, i_cmd.term);
            endcase
        end else begin
            case (i_cmd.term)
                2'd0:    begin c_ma = r_acl[i_cmd.grp]; c_mb = f20(r_gp, i_cmd.grp); end
                2'd1:    begin c_ma = r_int[i_cmd.grp]; c_mb = f20(r_gi, i_cmd.grp); end
                default: begin c_ma = r_rcl[i_cmd.grp]; c_mb = f20(r_gd, i_cmd.grp); end
            endcase
        end
        c_mul = c_ma * c_mb;
    end

    logic signed [55:0] c_sum;
    assign c_sum = ((r_pterm == 2'd0) ? 56'sd0 : r_acc) + 56'(r_prod);

    // one shift-add divide step, at most two subtracts
    logic [39:0] c_r0, c_r1, c_r2;
    logic [1:0]  c_qd;
    always_comb begin
        c_r0 = {1'b0, r_rem, 1'b0} + (r_lim[i_cmd.bitn] ? 40'(r_wmag) : 40'd0);
        c_qd = 2'd0;
        c_r1 = c_r0;
        if (c_r0 >= 40'(r_wmax)) begin
            c_r1 = c_r0 - 40'(r_wmax);
            c_qd = 2'd1;
        end
        c_r2 = c_r1;
        if (c_r1 >= 40'(r_wmax)) begin
            c_r2 = c_r1 - 40'(r_wmax);
            c_qd = 2'd2;
        end
    end

    logic [37:0] c_m [3];
    logic [37:0] c_wmax;
    always_comb begin
        c_wmax = '0;
        for (int j = 0; j < 3; j++) begin
            c_m[j] = mag38(r_wheel[j]);
            if (c_m[j] > c_wmax)
                c_wmax = c_m[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gp    <= '0;
            r_gi    <= '0;
            r_gd    <= '0;
            r_row_a <= '0;
            r_row_b <= '0;
            r_row_c <= '0;
            r_lim   <= LIMIT_RESET;
            r_pv    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_pa[i] <= '0;
                r_pi[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GAIN_P: r_gp    <= i_cfg_data;
                    CFG_GAIN_I: r_gi    <= i_cfg_data;
                    CFG_GAIN_D: r_gd    <= i_cfg_data;
                    CFG_ROW_A:  r_row_a <= i_cfg_data;
                    CFG_ROW_B:  r_row_b <= i_cfg_data;
                    CFG_ROW_C:  r_row_c <= i_cfg_data;
                    CFG_LIMIT:  r_lim   <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            r_pv <= (i_cmd.op == OP_MUL);
            if (i_cmd.op == OP_PREP) begin
                for (int i = 0; i < 3; i++) begin
                    r_pa[i] <= r_att[i];
                    r_pi[i] <= c_int[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_att[0]  <= i_att_err_x;
                r_att[1]  <= i_att_err_y;
                r_att[2]  <= i_att_err_z;
                r_rate[0] <= i_rate_err_x;
                r_rate[1] <= i_rate_err_y;
                r_rate[2] <= i_rate_err_z;
                r_rst     <= i_restart;
            end
            OP_PREP: begin
                r_settled <= c_settled;
                for (int i = 0; i < 3; i++) begin
                    r_int[i] <= c_int[i];
                    r_acl[i] <= clampv(34'(r_att[i]), CLAMP_ATT);
                    r_rcl[i] <= clampv(34'(r_rate[i]), CLAMP_RATE);
                end
            end
            OP_MUL: begin
                r_prod   <= c_mul;
                r_palign <= i_cmd.align;
                r_pgrp   <= i_cmd.grp;
                r_pterm  <= i_cmd.term;
            end
            OP_MAX: begin
                r_wmax   <= c_wmax;
                r_scaled <= (c_wmax >= 38'(r_lim));
            end
            OP_DIV_INIT: begin
                r_rem  <= '0;
                r_q    <= '0;
                r_wmag <= c_m[i_cmd.lane];
                r_wneg <= r_wheel[i_cmd.lane][37];
            end
            OP_DIV_STEP: begin
                r_rem <= c_r2[37:0];
                r_q   <= {r_q[30:0], 1'b0} + 32'(c_qd);
            end
            OP_DIV_END: begin
                // zero divisor gives a zero quotient
                if (r_wmax == '0)
                    r_wheel[i_cmd.lane] <= '0;
                else if (r_wneg)
                    r_wheel[i_cmd.lane] <= -38'(r_q);
                else
                    r_wheel[i_cmd.lane] <= 38'(r_q);
            end
            OP_OUT: begin
                o_settled        <= r_settled;
                o_body_torque_x  <= r_body[0];
                o_body_torque_y  <= r_body[1];
                o_body_torque_z  <= r_body[2];
                o_wheel_torque_a <= sat32(56'(r_wheel[0]));
                o_wheel_torque_b <= sat32(56'(r_wheel[1]));
                o_wheel_torque_c <= sat32(56'(r_wheel[2]));
                o_int_lim_x      <= r_int[0][18:0];
                o_int_lim_y      <= r_int[1][18:0];
                o_int_lim_z      <= r_int[2][18:0];
                o_wheel_scaled   <= r_scaled;
            end
            default: ;
        endcase
        if (r_pv) begin
            r_acc <= c_sum;
            if (r_pterm == 2'd2) begin
                if (r_palign)
                    r_wheel[r_pgrp] <= c_sum[55:18];
                else
                    r_body[r_pgrp] <= sat32(c_sum >>> 16);
            end
        end
    end

    assign o_stat.scaled = r_scaled;

endmodule

// ----- rtl/core/three_axis_pid_torque_command.sv -----
// channel   valid        stall        payload
// input     i_in_valid   o_in_stall   i_att_err_*, i_rate_err_*, i_restart
// output    o_out_valid  i_out_stall  o_settled, o_body_torque_*, o_wheel_torque_*,
//                                     o_int_lim_*, o_wheel_scaled
// config    i_cfg_we     (none)       i_cfg_idx, i_cfg_data
//
// One item at a time; when the wheel torques are rescaled, three 31-step
// shift-subtract divides run on one shared unit.
// The 18 products go through one shared 32x20 multiplier, one per cycle.
// Reset clears gains, matrix and history; the limit returns to 16777.
// Input stall is high while an item is in work; a held result does not block
// the next transfer in, only the handover of the following result.
module three_axis_pid_torque_command (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_att_err_x,
    input  logic signed [31:0] i_att_err_y,
    input  logic signed [31:0] i_att_err_z,
    input  logic signed [31:0] i_rate_err_x,
    input  logic signed [31:0] i_rate_err_y,
    input  logic signed [31:0] i_rate_err_z,
    input  logic               i_restart,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_settled,
    output logic signed [31:0] o_body_torque_x,
    output logic signed [31:0] o_body_torque_y,
    output logic signed [31:0] o_body_torque_z,
    output logic signed [31:0] o_wheel_torque_a,
    output logic signed [31:0] o_wheel_torque_b,
    output logic signed [31:0] o_wheel_torque_c,
    output logic signed [18:0] o_int_lim_x,
    output logic signed [18:0] o_int_lim_y,
    output logic signed [18:0] o_int_lim_z,
    output logic               o_wheel_scaled,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [59:0]        i_cfg_data
);
    import tapid_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    tapid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    tapid_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_att_err_x      (i_att_err_x),
        .i_att_err_y      (i_att_err_y),
        .i_att_err_z      (i_att_err_z),
        .i_rate_err_x     (i_rate_err_x),
        .i_rate_err_y     (i_rate_err_y),
        .i_rate_err_z     (i_rate_err_z),
        .i_restart        (i_restart),
        .o_settled        (o_settled),
        .o_body_torque_x  (o_body_torque_x),
        .o_body_torque_y  (o_body_torque_y),
        .o_body_torque_z  (o_body_torque_z),
        .o_wheel_torque_a (o_wheel_torque_a),
        .o_wheel_torque_b (o_wheel_torque_b),
        .o_wheel_torque_c (o_wheel_torque_c),
        .o_int_lim_x      (o_int_lim_x),
        .o_int_lim_y      (o_int_lim_y),
        .o_int_lim_z      (o_int_lim_z),
        .o_wheel_scaled   (o_wheel_scaled)
    );

`ifndef ASSERT_OFF
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after transfer");

    a_unsettled_int_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_settled) |->
            (o_int_lim_x == 19'sd0 && o_int_lim_y == 19'sd0 && o_int_lim_z == 19'sd0))
        else $error("integral nonzero while unsettled");

    a_idle_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> (!o_in_stall && !o_out_valid))
        else $error("not idle after reset");
`endif

endmodule

// ----- dv/three_axis_pid_torque_command_checker.sv -----
module three_axis_pid_torque_command_checker
    import tapid_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [31:0] i_att_err_x,
    input  logic signed [31:0] i_att_err_y,
    input  logic signed [31:0] i_att_err_z,
    input  logic signed [31:0] i_rate_err_x,
    input  logic signed [31:0] i_rate_err_y,
    input  logic signed [31:0] i_rate_err_z,
    input  logic               i_restart,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_settled,
    input  logic signed [31:0] i_body_torque_x,
    input  logic signed [31:0] i_body_torque_y,
    input  logic signed [31:0] i_body_torque_z,
    input  logic signed [31:0] i_wheel_torque_a,
    input  logic signed [31:0] i_wheel_torque_b,
    input  logic signed [31:0] i_wheel_torque_c,
    input  logic signed [18:0] i_int_lim_x,
    input  logic signed [18:0] i_int_lim_y,
    input  logic signed [18:0] i_int_lim_z,
    input  logic               i_wheel_scaled,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [59:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        settled;
        logic [31:0] bx, by, bz;
        logic [31:0] wa, wb, wc;
        logic [18:0] ix, iy, iz;
        logic        scaled;
    } t_torque;

    t_torque     torque_q[$];
    logic [59:0] kp, ki, kd;
    logic [59:0] row[3];
    logic [30:0] wheel_limit;
    longint      last_att[3];
    longint      last_int[3];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = torque_q.size();

    function automatic longint field20(logic [59:0] word, int k);
        logic signed [19:0] f;
        f = word[20*k +: 20];
        return longint'(f);
    endfunction

    function automatic longint magn(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint sat_dw(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // one control tick; updates the integrator history
    function automatic t_torque pid_tick(longint att[3], longint rate[3], logic rs);
        t_torque     res;
        longint      integ[3], body[3], wheel[3];
        longint      amax, rmax, wmax, acc, lim;
        logic        settle;
        logic        scl;
        logic [127:0] prod;
        longint      q;
        amax = 0;
        rmax = 0;
        wmax = 0;
        if (rs) begin
            for (int i = 0; i < 3; i++) begin
                last_att[i] = 0;
                last_int[i] = 0;
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (magn(att[i]) > amax) amax = magn(att[i]);
            if (magn(rate[i]) > rmax) rmax = magn(rate[i]);
        end
        settle = !(amax > longint'(SETTLE_ATT) || rmax > longint'(SETTLE_RATE));
        for (int i = 0; i < 3; i++) begin
            integ[i] = settle ? last_int[i] + ((att[i] + last_att[i]) >>> 1) : 0;
            integ[i] = clip(integ[i], longint'(CLAMP_INT));
            acc = clip(att[i], longint'(CLAMP_ATT)) * field20(kp, i)
                + integ[i] * field20(ki, i)
                + clip(rate[i], longint'(CLAMP_RATE)) * field20(kd, i);
            body[i] = sat_dw(acc >>> 16);
        end
        for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int i = 0; i < 3; i++)
                acc += body[i] * field20(row[j], i);
            wheel[j] = acc >>> 18;
            if (magn(wheel[j]) > wmax) wmax = magn(wheel[j]);
        end
        lim = longint'({33'd0, wheel_limit});
        scl = (wmax >= lim);
        for (int j = 0; j < 3; j++) begin
            if (scl) begin
                if (wmax == 0) begin
                    q = 0;
                end else begin
                    prod = 128'(magn(wheel[j])) * 128'(lim);
                    q = longint'(prod / 128'(wmax));
                end
                wheel[j] = (wheel[j] < 0) ? -q : q;
            end
            wheel[j] = sat_dw(wheel[j]);
        end
        for (int i = 0; i < 3; i++) begin
            last_att[i] = att[i];
            last_int[i] = integ[i];
        end
        res.settled = settle;
        res.bx = body[0][31:0];
        res.by = body[1][31:0];
        res.bz = body[2][31:0];
        res.wa = wheel[0][31:0];
        res.wb = wheel[1][31:0];
        res.wc = wheel[2][31:0];
        res.ix = integ[0][18:0];
        res.iy = integ[1][18:0];
        res.iz = integ[2][18:0];
        res.scaled = scl;
        return res;
    endfunction

    always @(posedge i_clk) begin
        longint  att[3], rate[3];
        t_torque got, want;
        if (!i_rst_n) begin
            kp = '0;
            ki = '0;
            kd = '0;
            for (int i = 0; i < 3; i++) begin
                row[i] = '0;
                last_att[i] = 0;
                last_int[i] = 0;
            end
            wheel_limit = LIMIT_RESET;
            torque_q.delete();
            fails = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_settled, i_body_torque_x, i_body_torque_y, i_body_torque_z,
                        i_wheel_torque_a, i_wheel_torque_b, i_wheel_torque_c,
                        i_int_lim_x, i_int_lim_y, i_int_lim_z, i_wheel_scaled};
                if (torque_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("ERROR: result transfer with nothing expected: %h", got);
                end else begin
                    want = torque_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("ERROR: torque mismatch at %0t", $realtime);
                            $display("  settled exp %0d got %0d, scaled exp %0d got %0d",
                                     want.settled, got.settled, want.scaled, got.scaled);
                            $display("  body  exp %h %h %h got %h %h %h",
                                     want.bx, want.by, want.bz, got.bx, got.by, got.bz);
                            $display("  wheel exp %h %h %h got %h %h %h",
                                     want.wa, want.wb, want.wc, got.wa, got.wb, got.wc);
                            $display("  int   exp %h %h %h got %h %h %h",
                                     want.ix, want.iy, want.iz, got.ix, got.iy, got.iz);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                att[0]  = longint'(i_att_err_x);
                att[1]  = longint'(i_att_err_y);
                att[2]  = longint'(i_att_err_z);
                rate[0] = longint'(i_rate_err_x);
                rate[1] = longint'(i_rate_err_y);
                rate[2] = longint'(i_rate_err_z);
                torque_q.push_back(pid_tick(att, rate, i_restart));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GAIN_P: kp = i_cfg_data;
                    CFG_GAIN_I: ki = i_cfg_data;
                    CFG_GAIN_D: kd = i_cfg_data;
                    CFG_ROW_A:  row[0] = i_cfg_data;
                    CFG_ROW_B:  row[1] = i_cfg_data;
                    CFG_ROW_C:  row[2] = i_cfg_data;
                    CFG_LIMIT:  wheel_limit = i_cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- dv/tb.sv -----
module tb;
    import tapid_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] ax = '0, ay = '0, az = '0;
    logic signed [31:0] rx = '0, ry = '0, rz = '0;
    logic               restart = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               settled, wscaled;
    logic signed [31:0] bx, by, bz, wa, wb, wc;
    logic signed [18:0] ix, iy, iz;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_idx = '0;
    logic [59:0]        cfg_data = '0;
    int                 fail_count, pending;
    int                 idle_pct = 0;
    int                 stall_pct = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    three_axis_pid_torque_command u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_att_err_x(ax), .i_att_err_y(ay), .i_att_err_z(az),
        .i_rate_err_x(rx), .i_rate_err_y(ry), .i_rate_err_z(rz),
        .i_restart(restart),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_settled(settled),
        .o_body_torque_x(bx), .o_body_torque_y(by), .o_body_torque_z(bz),
        .o_wheel_torque_a(wa), .o_wheel_torque_b(wb), .o_wheel_torque_c(wc),
        .o_int_lim_x(ix), .o_int_lim_y(iy), .o_int_lim_z(iz),
        .o_wheel_scaled(wscaled),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    three_axis_pid_torque_command_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_att_err_x(ax), .i_att_err_y(ay), .i_att_err_z(az),
        .i_rate_err_x(rx), .i_rate_err_y(ry), .i_rate_err_z(rz),
        .i_restart(restart),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_settled(settled),
        .i_body_torque_x(bx), .i_body_torque_y(by), .i_body_torque_z(bz),
        .i_wheel_torque_a(wa), .i_wheel_torque_b(wb), .i_wheel_torque_c(wc),
        .i_int_lim_x(ix), .i_int_lim_y(iy), .i_int_lim_z(iz),
        .i_wheel_scaled(wscaled),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);

    task automatic send_tick(logic signed [31:0] a0, a1, a2, r0, r1, r2, logic rs);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        {ax, ay, az, rx, ry, rz, restart} = {a0, a1, a2, r0, r1, r2, rs};
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [59:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [59:0] rand60();
        return {$urandom, $urandom};
    endfunction

    // small gain / matrix entries keep the wheel torques near the limit
    function automatic logic [59:0] rand_entries(int span);
        logic [59:0] v;
        for (int k = 0; k < 3; k++)
            v[20*k +: 20] = 20'($urandom_range(2 * span) - span);
        return v;
    endfunction

    task automatic load_setting(int sel);
        case (sel)
            0: begin
                write_reg(CFG_GAIN_P, {3{20'h10000}});
                write_reg(CFG_GAIN_I, {3{20'h08000}});
                write_reg(CFG_GAIN_D, {3{20'h04000}});
                write_reg(CFG_ROW_A, {20'h0, 20'h0, 20'h40000});
                write_reg(CFG_ROW_B, {20'h0, 20'h40000, 20'h0});
                write_reg(CFG_ROW_C, {20'h40000, 20'h0, 20'h0});
                write_reg(CFG_LIMIT, 60'(LIMIT_RESET));
            end
            1: begin
                write_reg(CFG_GAIN_P, {3{20'h7FFFF}});
                write_reg(CFG_GAIN_I, {3{20'h7FFFF}});
                write_reg(CFG_GAIN_D, {3{20'h7FFFF}});
                write_reg(CFG_ROW_A, {3{20'h7FFFF}});
                write_reg(CFG_ROW_B, {3{20'h80000}});
                write_reg(CFG_ROW_C, {3{20'hFFFFF}});
                write_reg(CFG_LIMIT, 60'h7FFFFFFF);
            end
            2: begin
                write_reg(CFG_GAIN_P, {3{20'h80000}});
                write_reg(CFG_GAIN_I, {3{20'h80000}});
                write_reg(CFG_GAIN_D, {3{20'h80000}});
                write_reg(CFG_ROW_A, {3{20'h80000}});
                write_reg(CFG_ROW_B, {3{20'h7FFFF}});
                write_reg(CFG_ROW_C, rand60());
                write_reg(CFG_LIMIT, 60'd1);
            end
            default: begin
                write_reg(CFG_GAIN_P, $urandom_range(1) ? rand60() : rand_entries(200000));
                write_reg(CFG_GAIN_I, $urandom_range(1) ? rand60() : rand_entries(200000));
                write_reg(CFG_GAIN_D, $urandom_range(1) ? rand60() : rand_entries(200000));
                write_reg(CFG_ROW_A, $urandom_range(1) ? rand60() : rand_entries(300000));
                write_reg(CFG_ROW_B, $urandom_range(1) ? rand60() : rand_entries(300000));
                write_reg(CFG_ROW_C, $urandom_range(1) ? rand60() : rand_entries(300000));
                case ($urandom_range(3))
                    0: write_reg(CFG_LIMIT, 60'($urandom_range(1, 20000)));
                    1: write_reg(CFG_LIMIT, 60'($urandom_range(1, 32'h7FFFFFFF)));
                    2: write_reg(CFG_LIMIT, 60'($urandom_range(1, 2000000)));
                    default: write_reg(CFG_LIMIT, 60'($urandom_range(1, 200000000)));
                endcase
            end
        endcase
    endtask

    function automatic logic signed [31:0] near(int span);
        return 32'($urandom_range(2 * span) - span);
    endfunction

    task automatic random_tick();
        int  mode;
        logic rs;
        mode = $urandom_range(99);
        rs = ($urandom_range(19) == 0);
        if (mode < 75)
            send_tick(near(170000), near(170000), near(170000),
                      near(680000), near(680000), near(680000), rs);
        else if (mode < 88)
            send_tick(near(3000000), near(3000000), near(3000000),
                      near(170000000), near(170000000), near(170000000), rs);
        else
            send_tick($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      1'($urandom));
    endtask

    initial begin
        logic signed [31:0] smax, smin;
        smax = 32'sh7FFFFFFF;
        smin = 32'sh80000000;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings first, then directed corners
        send_tick(32'sd1000, -32'sd1000, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0);
        drain();
        load_setting(0);
        send_tick(0, 0, 0, 0, 0, 0, 1'b1);
        send_tick(smax, smin, 0, 0, 0, 0, 1'b0);
        send_tick(0, 0, 0, smax, smin, smax, 1'b0);
        send_tick(smin, smin, smin, smin, smin, smin, 1'b1);
        send_tick(smax, smax, smax, smax, smax, smax, 1'b0);
        // right at and just past the settling thresholds
        send_tick(SETTLE_ATT, -SETTLE_ATT, 0, SETTLE_RATE, -SETTLE_RATE, 0, 1'b1);
        send_tick(SETTLE_ATT + 1, 0, 0, 0, 0, 0, 1'b0);
        send_tick(0, 0, 0, 0, 0, -SETTLE_RATE - 1, 1'b0);
        // integrate up to the integral clamp from both sides
        for (int k = 0; k < 5; k++)
            send_tick(SETTLE_ATT, SETTLE_ATT, -SETTLE_ATT, 0, 0, 0, 1'b0);
        send_tick(-SETTLE_ATT, -SETTLE_ATT, SETTLE_ATT, 0, 0, 0, 1'b0);
        send_tick(-1, -1, 1, 0, 0, 0, 1'b1);
        send_tick(-1, 1, -1, 1, -1, 1, 1'b0);
        send_tick(CLAMP_ATT, -CLAMP_ATT, CLAMP_ATT + 1, CLAMP_RATE, -CLAMP_RATE - 1, 0, 1'b0);
        drain();
        load_setting(1);
        send_tick(smax, smin, smax, smin, smax, smin, 1'b0);
        send_tick(SETTLE_ATT, SETTLE_ATT, SETTLE_ATT, SETTLE_RATE, 0, 0, 1'b1);
        drain();
        load_setting(2);
        send_tick(smax, smin, smax, smin, smax, smin, 1'b0);
        send_tick(0, 0, 0, 0, 0, 0, 1'b0);
        send_tick(SETTLE_ATT, -SETTLE_ATT, SETTLE_ATT, 0, 0, 0, 1'b1);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            load_setting(phase == 1 ? 1 : (phase == 5 ? 2 : 3));
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 76; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 76; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            for (int n = 0; n < 240; n++) begin
                if (phase == 2 && n == 120) begin
                    // hold the sender until the output side has caught up
                    @(negedge clk);
                    in_valid = 1'b0;
                    while (pending != 0) @(posedge clk);
                end
                random_tick();
            end
            drain();
        end

        if (fail_count == 0)
            $display("three_axis_pid_torque_command regression: pass");
        else
            $display("three_axis_pid_torque_command regression: fail");
        $finish;
    end

    initial begin
        #40ms;
        $display("three_axis_pid_torque_command regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/tapid_pkg.sv
rtl/core/tapid_ctrl.sv
rtl/core/tapid_dp.sv
rtl/core/three_axis_pid_torque_command.sv
dv/three_axis_pid_torque_command_checker.sv
dv/tb.sv
